[hdl/irhc_pkg.sv]
package irhc_pkg;

   // crank validity thresholds for the running flag hysteresis
   localparam logic [2:0] DETECTED_LEVEL = 3'd1;
   localparam logic [2:0] SYNCED_LEVEL   = 3'd2;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_DEBOUNCE_RISE = 3'd0,
      REG_DEBOUNCE_FALL = 3'd1,
      REG_HOLD_IGN      = 3'd2,
      REG_HOLD_COMP     = 3'd3,
      REG_HOLD_CRANK    = 3'd4,
      REG_MODE_FLAGS    = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      READ_OK        = 2'd0,
      READ_NOT_READY = 2'd1,
      READ_ERROR     = 2'd2
   } read_status_type;

   localparam int MODE_INVERT = 0;
   localparam int MODE_COMP   = 1;
   localparam int MODE_CRANK  = 2;
   localparam int MODE_RELAY  = 3;

   typedef struct packed {
      logic [31:0] debounce_rise_us;
      logic [31:0] debounce_fall_us;
      logic [31:0] hold_after_ignition_us;
      logic [31:0] hold_after_components_us;
      logic [31:0] hold_after_crank_us;
      logic [3:0]  mode_flags;
   } cfg_type;

   typedef struct packed {
      logic [31:0] now_us;
      logic        pin_level;
      logic [1:0]  read_status;
      logic        components_running;
      logic        crank_update;
      logic [2:0]  crank_validity;
      logic        relay_write_fails;
   } req_item_type;

   typedef struct packed {
      logic ignition_on;
      logic ignition_changed;
      logic relay_drive;
      logic relay_write;
      logic components_hold;
      logic crank_hold;
      logic input_error;
      logic relay_error;
   } rsp_item_type;

endpackage

[hdl/ignition_relay_hold_controller_top.sv]
// Ignition relay hold controller. Each poll item enters an input register and is
// processed as it moves into the result register, in the next cycle unless the result
// is stalled: one item per clock sustained while rsp_stall is low. The debouncer, the three
// hold-off timers and the relay write/retry logic share one combinational pass that
// updates the controller state as the item moves to the result register, so items
// are handled strictly in order. req_stall rises only when both registers are full
// and the result is stalled. Registers sit at byte addresses 0x00 to 0x14 of the APB
// port and should be written while no item is in flight; after reset the relay drive
// is on until the hold-off times have run out.
module ignition_relay_hold_controller_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  irhc_pkg::req_item_type           req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output irhc_pkg::rsp_item_type           rsp_data,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [irhc_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [irhc_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [irhc_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);
   import irhc_pkg::*;

   cfg_type      cfg;
   req_item_type item_ff;
   logic         item_valid_ff, item_valid_in;
   rsp_item_type rsp_data_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type result;
   logic         advance;
   logic         accept;

   irhc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   irhc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .item   (item_ff),
      .fire   (advance),
      .result (result)
   );

   // advance the held item when the result register is free or being drained
   assign advance   = item_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = item_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      item_valid_in = item_valid_ff;
      if (accept) begin
         item_valid_in = 1'b1;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   advance_fills_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced item did not reach the result register");

   stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> item_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("input stalled with room in the pipeline");

   write_needs_relay: assert property (@(posedge clock) disable iff (reset)
      advance && result.relay_write |-> cfg.mode_flags[MODE_RELAY])
      else $error("relay write strobe without relay present");

endmodule

[hdl/irhc_csr.sv]
module irhc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [irhc_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [irhc_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [irhc_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready,
   output irhc_pkg::cfg_type                cfg
);
   import irhc_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign index  = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_DEBOUNCE_RISE: cfg_in.debounce_rise_us         = pwdata;
            REG_DEBOUNCE_FALL: cfg_in.debounce_fall_us         = pwdata;
            REG_HOLD_IGN:      cfg_in.hold_after_ignition_us   = pwdata;
            REG_HOLD_COMP:     cfg_in.hold_after_components_us = pwdata;
            REG_HOLD_CRANK:    cfg_in.hold_after_crank_us      = pwdata;
            REG_MODE_FLAGS:    cfg_in.mode_flags               = pwdata[3:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_DEBOUNCE_RISE: prdata = cfg_ff.debounce_rise_us;
         REG_DEBOUNCE_FALL: prdata = cfg_ff.debounce_fall_us;
         REG_HOLD_IGN:      prdata = cfg_ff.hold_after_ignition_us;
         REG_HOLD_COMP:     prdata = cfg_ff.hold_after_components_us;
         REG_HOLD_CRANK:    prdata = cfg_ff.hold_after_crank_us;
         REG_MODE_FLAGS:    prdata = {28'd0, cfg_ff.mode_flags};
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[hdl/irhc_core.sv]
module irhc_core (
   input  logic                   clock,
   input  logic                   reset,
   input  irhc_pkg::cfg_type      cfg,
   input  irhc_pkg::req_item_type item,
   input  logic                   fire,
   output irhc_pkg::rsp_item_type result
);
   import irhc_pkg::*;

   logic        ign_state_ff,       ign_state_in;
   logic [31:0] level_stamp_ff,     level_stamp_in;
   logic [31:0] ign_off_stamp_ff,   ign_off_stamp_in;
   logic [31:0] comp_off_stamp_ff,  comp_off_stamp_in;
   logic [31:0] crank_off_stamp_ff, crank_off_stamp_in;
   logic        ign_hold_done_ff,   ign_hold_done_in;
   logic        comp_hold_done_ff,  comp_hold_done_in;
   logic        crank_hold_done_ff, crank_hold_done_in;
   logic        crank_running_ff,   crank_running_in;
   logic        applied_drive_ff,   applied_drive_in;
   logic        input_err_ff,       input_err_in;
   logic        relay_err_ff,       relay_err_in;

   logic        level;
   logic        changed;
   logic        comp_trig;
   logic        crank_trig;
   logic        drive;
   logic        strobe;
   logic [31:0] span;
   logic [31:0] now;

   assign now = item.now_us;

   always_comb begin
      crank_running_in   = crank_running_ff;
      input_err_in       = input_err_ff;
      level              = ign_state_ff;
      ign_state_in       = ign_state_ff;
      level_stamp_in     = level_stamp_ff;
      ign_off_stamp_in   = ign_off_stamp_ff;
      ign_hold_done_in   = ign_hold_done_ff;
      comp_off_stamp_in  = comp_off_stamp_ff;
      comp_hold_done_in  = comp_hold_done_ff;
      crank_off_stamp_in = crank_off_stamp_ff;
      crank_hold_done_in = crank_hold_done_ff;
      applied_drive_in   = applied_drive_ff;
      relay_err_in       = relay_err_ff;
      changed            = 1'b0;
      strobe             = 1'b0;

      // crank level is applied before this item's poll
      if (item.crank_update) begin
         if (item.crank_validity < DETECTED_LEVEL) begin
            crank_running_in = 1'b0;
         end else if (item.crank_validity >= SYNCED_LEVEL) begin
            crank_running_in = 1'b1;
         end
      end

      case (read_status_type'(item.read_status))
         READ_OK:        level = item.pin_level ^ cfg.mode_flags[MODE_INVERT];
         READ_NOT_READY: level = ign_state_ff;
         default:        input_err_in = 1'b1;
      endcase

      span = level ? cfg.debounce_rise_us : cfg.debounce_fall_us;
      if (level != ign_state_ff) begin
         if (now - level_stamp_ff >= span) begin
            ign_state_in   = level;
            level_stamp_in = now;
            changed        = 1'b1;
         end
      end else begin
         level_stamp_in = now;
      end

      if (ign_state_in) begin
         ign_off_stamp_in = now;
         ign_hold_done_in = 1'b0;
      end else if (!ign_hold_done_ff &&
                   (now - ign_off_stamp_ff >= cfg.hold_after_ignition_us)) begin
         ign_hold_done_in = 1'b1;
      end

      comp_trig = 1'b0;
      if (!cfg.mode_flags[MODE_COMP]) begin
         comp_off_stamp_in = now;
         comp_hold_done_in = 1'b1;
      end else if (item.components_running) begin
         comp_trig         = 1'b1;
         comp_off_stamp_in = now;
         comp_hold_done_in = 1'b0;
      end else if (!comp_hold_done_ff &&
                   (now - comp_off_stamp_ff >= cfg.hold_after_components_us)) begin
         comp_hold_done_in = 1'b1;
      end

      crank_trig = 1'b0;
      if (!cfg.mode_flags[MODE_CRANK]) begin
         crank_off_stamp_in = now;
         crank_hold_done_in = 1'b1;
      end else if (crank_running_in) begin
         crank_trig         = 1'b1;
         crank_off_stamp_in = now;
         crank_hold_done_in = 1'b0;
      end else if (!crank_hold_done_ff &&
                   (now - crank_off_stamp_ff >= cfg.hold_after_crank_us)) begin
         crank_hold_done_in = 1'b1;
      end

      drive = ign_state_in || !ign_hold_done_in || comp_trig || !comp_hold_done_in ||
              crank_trig || !crank_hold_done_in;

      // hold applied drive on a failed write so the next item retries
      if (drive != applied_drive_ff) begin
         if (cfg.mode_flags[MODE_RELAY]) begin
            strobe = 1'b1;
            if (item.relay_write_fails) begin
               relay_err_in = 1'b1;
            end else begin
               applied_drive_in = drive;
            end
         end else begin
            applied_drive_in = drive;
         end
      end
   end

   always_comb begin
      result.ignition_on      = ign_state_in;
      result.ignition_changed = changed;
      result.relay_drive      = drive;
      result.relay_write      = strobe;
      result.components_hold  = comp_trig;
      result.crank_hold       = crank_trig;
      result.input_error      = input_err_in;
      result.relay_error      = relay_err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ign_state_ff       <= 1'b0;
         level_stamp_ff     <= '0;
         ign_off_stamp_ff   <= '0;
         comp_off_stamp_ff  <= '0;
         crank_off_stamp_ff <= '0;
         ign_hold_done_ff   <= 1'b0;
         comp_hold_done_ff  <= 1'b0;
         crank_hold_done_ff <= 1'b0;
         crank_running_ff   <= 1'b0;
         applied_drive_ff   <= 1'b0;
         input_err_ff       <= 1'b0;
         relay_err_ff       <= 1'b0;
      end else if (fire) begin
         ign_state_ff       <= ign_state_in;
         level_stamp_ff     <= level_stamp_in;
         ign_off_stamp_ff   <= ign_off_stamp_in;
         comp_off_stamp_ff  <= comp_off_stamp_in;
         crank_off_stamp_ff <= crank_off_stamp_in;
         ign_hold_done_ff   <= ign_hold_done_in;
         comp_hold_done_ff  <= comp_hold_done_in;
         crank_hold_done_ff <= crank_hold_done_in;
         crank_running_ff   <= crank_running_in;
         applied_drive_ff   <= applied_drive_in;
         input_err_ff       <= input_err_in;
         relay_err_ff       <= relay_err_in;
      end
   end

   sticky_input_err: assert property (@(posedge clock) disable iff (reset)
      input_err_ff |=> input_err_ff)
      else $error("input error flag cleared outside reset");

   sticky_relay_err: assert property (@(posedge clock) disable iff (reset)
      relay_err_ff |=> relay_err_ff)
      else $error("relay error flag cleared outside reset");

   change_pulse: assert property (@(posedge clock) disable iff (reset)
      fire && result.ignition_changed |=> ign_state_ff != $past(ign_state_ff))
      else $error("ignition change reported without state change");

endmodule
